/* rtl/srbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_pkg
// Shared types and constants of the symmetric relation bit matrix.
// ----------------------------------------------------------------------------
package srbm_pkg;

	localparam int ITEM_W    = 6;
	localparam int ROW_W     = 1 << ITEM_W;
	localparam int ROW_SLOTS = 1 << ITEM_W;
	localparam int NUM_ITEMS = 64;
	localparam int CNT_W     = $clog2(NUM_ITEMS + 1);

	typedef enum logic [1:0] {
		FN_READ   = 2'd0,
		FN_WRITE  = 2'd1,
		FN_INSERT = 2'd2,
		FN_MERGE  = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SRC   = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	function automatic logic [ROW_W-1:0] item_mask();
		logic [ROW_W-1:0] m;
		m = '0;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (i < NUM_ITEMS);
		end
		return m;
	endfunction

	function automatic logic [ROW_W-1:0] one_hot(input logic [ITEM_W-1:0] x);
		return ROW_W'(1) << x;
	endfunction

	function automatic logic item_ok(input logic [ITEM_W-1:0] x);
		return {1'b0, x} < (ITEM_W + 1)'(NUM_ITEMS);
	endfunction

endpackage

/* rtl/srbm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_req_if / srbm_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srbm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [5:0] item_a;
	logic [5:0] item_b;
	logic       bit_value;

	modport source (output valid, func, item_a, item_b, bit_value, input ready);
	modport sink (input valid, func, item_a, item_b, bit_value, output ready);
endinterface

interface srbm_rsp_if;
	logic valid;
	logic ready;
	logic pair_bit;
	logic status;

	modport source (output valid, pair_bit, status, input ready);
	modport sink (input valid, pair_bit, status, output ready);
endinterface

/* rtl/srbm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/symmetric_relation_bit_matrix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_relation_bit_matrix_top
// Symmetric, irreflexive relation over NUM_ITEMS items held as a bit matrix.
// ----------------------------------------------------------------------------
// One word in, one word out per request, one request at a time. The matrix
// sits in a 64 x 64 RAM with per-row valid flops, so reset clears it at once
// with no clearing pass. A read fetches one row from the RAM; a same-item
// request other than insert, or an out-of-range request, skips the RAM.
// Write and insert sweep every row through the RAM, one row per cycle with
// read and write-back overlapped. A merge first fetches the source row and
// then sweeps. A new request is taken while the last response
// still waits in the output register.
// ----------------------------------------------------------------------------
module symmetric_relation_bit_matrix_top
	import srbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srbm_req_if.sink   req,
	srbm_rsp_if.source rsp
);

	state_t                 state_q;
	func_t                  func_q;
	logic [ITEM_W-1:0]      a_q;
	logic [ITEM_W-1:0]      b_q;
	logic                   v_q;
	logic [ROW_W-1:0]       add_q;
	logic                   bit_q;
	logic                   status_q;
	logic [CNT_W-1:0]       k_q;
	logic                   rd_vld_s1;
	logic [ITEM_W-1:0]      addr_s1;
	logic [ROW_SLOTS-1:0]   valid_q;
	logic                   rsp_valid_q;
	logic                   rsp_bit_q;
	logic                   rsp_status_q;

	logic                   accept;
	logic                   sweep_more;
	logic [ITEM_W-1:0]      raddr;
	logic [ROW_W-1:0]       ram_rdata;
	logic [ROW_W-1:0]       row_s1;
	logic [ROW_W-1:0]       wrow;
	func_t                  in_func;

	assign in_func    = func_t'(req.func);
	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign sweep_more = (k_q < CNT_W'(NUM_ITEMS));
	assign raddr      = (state_q == ST_SWEEP) ? ITEM_W'(k_q) : a_q;
	assign row_s1     = valid_q[addr_s1] ? ram_rdata : '0;

	assign rsp.valid    = rsp_valid_q;
	assign rsp.pair_bit = rsp_bit_q;
	assign rsp.status   = rsp_status_q;

	srbm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROW_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (rd_vld_s1),
		.waddr(addr_s1),
		.wdata(wrow),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		wrow = row_s1;
		case (func_q)
			FN_WRITE: begin
				if (addr_s1 == a_q) wrow[b_q] = v_q;
				if (addr_s1 == b_q) wrow[a_q] = v_q;
			end
			FN_INSERT: begin
				wrow = (addr_s1 == a_q) ? '0 : (row_s1 & ~one_hot(a_q));
			end
			FN_MERGE: begin
				if (addr_s1 == b_q) begin
					wrow = row_s1 | add_q;
				end else if (add_q[addr_s1]) begin
					wrow = row_s1 | one_hot(b_q);
				end
			end
			default: wrow = row_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_vld_s1   <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SWEEP) && sweep_more;
			if (rd_vld_s1) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) begin
						if (in_func == FN_INSERT) begin
							state_q <= item_ok(req.item_a) ? ST_SWEEP : ST_DONE;
						end else if (req.item_a == req.item_b) begin
							state_q <= ST_DONE;
						end else if (!(item_ok(req.item_a) && item_ok(req.item_b))) begin
							state_q <= ST_DONE;
						end else if (in_func == FN_WRITE) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_SRC;
						end
					end
				end
				ST_SRC: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= (func_q == FN_READ) ? ST_DONE : ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sweep_more) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= in_func;
			a_q      <= req.item_a;
			b_q      <= req.item_b;
			v_q      <= req.bit_value;
			bit_q    <= 1'b0;
			status_q <= (in_func != FN_INSERT) && (req.item_a == req.item_b);
		end
		if (state_q == ST_SRC) begin
			addr_s1 <= a_q;
		end else if (state_q == ST_SWEEP) begin
			addr_s1 <= ITEM_W'(k_q);
		end
		if (state_q == ST_LOAD) begin
			bit_q <= (func_q == FN_READ) && row_s1[b_q];
			add_q <= row_s1 & item_mask() & ~one_hot(a_q) & ~one_hot(b_q);
		end
		if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_bit_q    <= bit_q;
			rsp_status_q <= status_q;
		end
	end

endmodule

/* rtl/srbm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_checker
// Port-level checks of the relation bit matrix, bound to the top level.
// ----------------------------------------------------------------------------
module srbm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_pair_bit,
	input logic rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_bit) && $stable(rsp_status))
		else $error("response word dropped or changed while stalled");

	a_err_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_pair_bit && rsp_status))
		else $error("error response carries a pair bit");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in flight");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared in the cycle after acceptance");

endmodule

bind symmetric_relation_bit_matrix_top srbm_checker u_srbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_pair_bit(rsp.pair_bit),
	.rsp_status  (rsp.status)
);
